// ===== src/scne_pkg.sv =====
package scne_pkg;

    // field and accumulator widths
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int MOD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int ACC_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // reciprocal of ten for a 32-bit dividend: q = (x * RECIP_10) >> RECIP_SHIFT
    localparam logic [ACC_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    // scan codes
    localparam logic [CODE_W-1:0] CODE_RELEASE = 8'h80;
    localparam logic [CODE_W-1:0] CODE_SHIFT   = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_CTRL    = 8'h1D;
    localparam logic [CODE_W-1:0] CODE_ALT     = 8'h38;

    // characters with a meaning for number entry
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 7'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 7'h39;

    // modifier bit positions
    localparam int MOD_SHIFT = 0;
    localparam int MOD_CTRL  = 1;
    localparam int MOD_ALT   = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNED_MODE = 1'b0,
        CFG_START_VALUE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] ch;
    } t_key;

    // set-1 translation, upper column chosen by shift
    function automatic t_key key_lookup(input logic [CODE_W-1:0] code, input logic shift);
        t_key               k;
        logic [2*CHAR_W-1:0] pair;
        k.hit = 1'b1;
        pair  = '0;
        unique case (code)
            8'h1E: pair = {7'h61, 7'h41};
            8'h30: pair = {7'h62, 7'h42};
            8'h2E: pair = {7'h63, 7'h43};
            8'h20: pair = {7'h64, 7'h44};
            8'h12: pair = {7'h65, 7'h45};
            8'h21: pair = {7'h66, 7'h46};
            8'h22: pair = {7'h67, 7'h47};
            8'h23: pair = {7'h68, 7'h48};
            8'h17: pair = {7'h69, 7'h49};
            8'h24: pair = {7'h6A, 7'h4A};
            8'h25: pair = {7'h6B, 7'h4B};
            8'h26: pair = {7'h6C, 7'h4C};
            8'h32: pair = {7'h6D, 7'h4D};
            8'h31: pair = {7'h6E, 7'h4E};
            8'h18: pair = {7'h6F, 7'h4F};
            8'h19: pair = {7'h70, 7'h50};
            8'h10: pair = {7'h71, 7'h51};
            8'h13: pair = {7'h72, 7'h52};
            8'h1F: pair = {7'h73, 7'h53};
            8'h14: pair = {7'h74, 7'h54};
            8'h16: pair = {7'h75, 7'h55};
            8'h2F: pair = {7'h76, 7'h56};
            8'h11: pair = {7'h77, 7'h57};
            8'h2D: pair = {7'h78, 7'h58};
            8'h15: pair = {7'h79, 7'h59};
            8'h2C: pair = {7'h7A, 7'h5A};
            // digit row
            8'h02: pair = {7'h31, 7'h21};
            8'h03: pair = {7'h32, 7'h22};
            8'h04: pair = {7'h33, 7'h40};
            8'h05: pair = {7'h34, 7'h24};
            8'h06: pair = {7'h35, 7'h25};
            8'h07: pair = {7'h36, 7'h26};
            8'h08: pair = {7'h37, 7'h2F};
            8'h09: pair = {7'h38, 7'h28};
            8'h0A: pair = {7'h39, 7'h29};
            8'h0B: pair = {7'h30, 7'h3D};
            // control keys
            8'h1C: pair = {7'h0A, 7'h0A};
            8'h01: pair = {7'h18, 7'h18};
            8'h0E: pair = {7'h08, 7'h08};
            8'h0F: pair = {7'h09, 7'h09};
            8'h39: pair = {7'h20, 7'h20};
            // punctuation
            8'h2B: pair = {7'h5C, 7'h7C};
            8'h28: pair = {7'h27, 7'h3F};
            8'h4E: pair = {7'h2B, 7'h2A};
            8'h33: pair = {7'h2C, 7'h3B};
            8'h34: pair = {7'h2E, 7'h3A};
            8'h0C: pair = {7'h2D, 7'h5F};
            default: k.hit = 1'b0;
        endcase
        k.ch = shift ? pair[CHAR_W-1:0] : pair[2*CHAR_W-1:CHAR_W];
        return k;
    endfunction

endpackage

// ===== src/scne_in_if.sv =====
interface scne_in_if;
    logic                        valid;
    logic                        ready;
    logic [scne_pkg::CODE_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

// ===== src/scne_out_if.sv =====
interface scne_out_if;
    logic                         valid;
    logic                         ready;
    logic [scne_pkg::CHAR_W-1:0]  char_out;
    logic                         char_valid;
    logic [scne_pkg::MOD_W-1:0]   modifiers;
    logic                         entry_done;
    logic [scne_pkg::VALUE_W-1:0] entry_value;

    modport source (output valid, output char_out, output char_valid, output modifiers,
                    output entry_done, output entry_value, input ready);
    modport sink   (input valid, input char_out, input char_valid, input modifiers,
                    input entry_done, input entry_value, output ready);
endinterface

// ===== src/scan_code_to_char_number_entry_unit.sv =====
// Set-1 scan code translator with decimal number entry. Each scan code transfer
// gives exactly one result transfer carrying the character (if any), the
// modifier flags after the code, and the finished value when a newline closes
// an entry. One scan code is taken every cycle while the result side is not
// stalled. A code passes an input register and then the result register
// before its result is offered. The cycle is set by the accumulator update
// loop, which holds the multiply by ten and the reciprocal multiply used for
// backspace. Configuration is sampled when an entry starts and must only be
// written while the unit is idle.
module scan_code_to_char_number_entry_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scne_in_if.sink                          i_in,
    scne_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [scne_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scne_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = scne_pkg::ACC_W;

    // configuration
    logic                r_signed_mode;
    logic [AW-1:0]       r_start_value;

    // entry state
    logic [scne_pkg::MOD_W-1:0] r_mods, n_mods;
    logic [AW-1:0]              r_acc, n_acc;
    logic                       r_neg, n_neg;
    logic                       r_entry_start, n_entry_start;

    // input stage
    logic                        r_s1_valid;
    logic [scne_pkg::CODE_W-1:0] r_s1_code;

    // result stage
    logic                          r_out_valid;
    logic [scne_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                          r_char_valid, n_char_valid;
    logic [scne_pkg::MOD_W-1:0]    r_out_mods;
    logic                          r_done, n_done;
    logic [scne_pkg::VALUE_W-1:0]  r_value, n_value;

    logic                  s2_free;
    logic                  s1_move;
    scne_pkg::t_key        key;
    logic                  is_digit;
    logic [AW-1:0]         base;
    logic                  neg_base;
    logic [AW-1:0]         digit;
    logic [2*AW-1:0]       prod;
    logic [AW-1:0]         quot;
    logic [AW-1:0]         signed_res;

    // handshake
    assign s2_free     = !r_out_valid || o_out.ready;
    assign s1_move     = r_s1_valid && s2_free;
    assign i_in.ready  = !r_s1_valid || s2_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
            r_start_value <= '0;
        end else if (i_cfg_we) begin
            unique case (scne_pkg::t_cfg_idx'(i_cfg_idx))
                scne_pkg::CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                scne_pkg::CFG_START_VALUE: r_start_value <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // modifier flags after this code
    always_comb begin
        n_mods = r_mods;
        if (r_s1_code == scne_pkg::CODE_SHIFT) n_mods[scne_pkg::MOD_SHIFT] = 1'b1;
        if (r_s1_code == (scne_pkg::CODE_SHIFT | scne_pkg::CODE_RELEASE))
            n_mods[scne_pkg::MOD_SHIFT] = 1'b0;
        if (r_s1_code == scne_pkg::CODE_CTRL) n_mods[scne_pkg::MOD_CTRL] = 1'b1;
        if (r_s1_code == (scne_pkg::CODE_CTRL | scne_pkg::CODE_RELEASE))
            n_mods[scne_pkg::MOD_CTRL] = 1'b0;
        if (r_s1_code == scne_pkg::CODE_ALT) n_mods[scne_pkg::MOD_ALT] = 1'b1;
        if (r_s1_code == (scne_pkg::CODE_ALT | scne_pkg::CODE_RELEASE))
            n_mods[scne_pkg::MOD_ALT] = 1'b0;
    end

    // translation
    assign key      = scne_pkg::key_lookup(r_s1_code, n_mods[scne_pkg::MOD_SHIFT]);
    assign is_digit = (key.ch >= scne_pkg::CH_ZERO) && (key.ch <= scne_pkg::CH_NINE);
    assign digit    = {{(AW-4){1'b0}}, key.ch[3:0]};

    // operand for an unsigned entry start or a running entry
    assign base     = r_entry_start ? r_start_value : r_acc;
    assign neg_base = r_entry_start ? 1'b0 : r_neg;

    // divide by ten through reciprocal multiply
    assign prod       = {{AW{1'b0}}, base} * {{AW{1'b0}}, scne_pkg::RECIP_10};
    assign quot       = {{(scne_pkg::RECIP_SHIFT-AW){1'b0}},
                         prod[2*AW-1:scne_pkg::RECIP_SHIFT]};
    assign signed_res = neg_base ? (~base + 1'b1) : base;

    // entry update
    always_comb begin
        n_acc         = r_acc;
        n_neg         = r_neg;
        n_entry_start = r_entry_start;
        n_char        = key.hit ? key.ch : '0;
        n_char_valid  = key.hit;
        n_done        = 1'b0;
        n_value       = '0;
        if (key.hit) begin
            if (r_entry_start && r_signed_mode) begin
                // first character of a signed entry is consumed on its own
                n_entry_start = 1'b0;
                n_acc         = is_digit ? digit : '0;
                n_neg         = (key.ch == scne_pkg::CH_MINUS);
            end else begin
                n_entry_start = 1'b0;
                n_acc         = base;
                n_neg         = neg_base;
                if (key.ch == scne_pkg::CH_BACKSPACE) begin
                    n_acc = quot;
                end else if (key.ch == scne_pkg::CH_NEWLINE) begin
                    n_done        = 1'b1;
                    n_value       = signed_res[scne_pkg::VALUE_W-1:0];
                    n_acc         = '0;
                    n_neg         = 1'b0;
                    n_entry_start = 1'b1;
                end else if (is_digit) begin
                    n_acc = (base << 3) + (base << 1) + digit;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_mods        <= '0;
            r_acc         <= '0;
            r_neg         <= 1'b0;
            r_entry_start <= 1'b1;
        end else begin
            if (i_in.ready) r_s1_valid <= i_in.valid;
            if (s2_free) r_out_valid <= r_s1_valid;
            if (s1_move) begin
                r_mods        <= n_mods;
                r_acc         <= n_acc;
                r_neg         <= n_neg;
                r_entry_start <= n_entry_start;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_s1_code <= i_in.scan_code;
        if (s1_move) begin
            r_char       <= n_char;
            r_char_valid <= n_char_valid;
            r_out_mods   <= n_mods;
            r_done       <= n_done;
            r_value      <= n_value;
        end
    end

    // result outputs
    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_char;
    assign o_out.char_valid  = r_char_valid;
    assign o_out.modifiers   = r_out_mods;
    assign o_out.entry_done  = r_done;
    assign o_out.entry_value = r_value;

`ifndef SYNTH
    // a finished entry always comes from a translated newline
    a_done_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.entry_done |->
            o_out.char_valid && o_out.char_out == scne_pkg::CH_NEWLINE)
        else $error("entry_done without newline");

    // no finished entry means a zero value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.entry_done |-> o_out.entry_value == '0)
        else $error("entry_value set without entry_done");

    // an entry waiting to start holds a cleared accumulator and sign
    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_start |-> r_acc == '0 && !r_neg)
        else $error("entry start with stale accumulator");

    // lower case letters only without shift
    a_lower_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.char_valid && o_out.char_out >= 7'h61 &&
            o_out.char_out <= 7'h7A |-> !o_out.modifiers[scne_pkg::MOD_SHIFT])
        else $error("lower case letter with shift held");
`endif

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scne_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 115;
    localparam int HOLD_CYCLES = 80;

    // scan codes used to build entries
    localparam logic [CODE_W-1:0] KEY_ENTER     = 8'h1C;
    localparam logic [CODE_W-1:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [CODE_W-1:0] KEY_MINUS     = 8'h0C;
    localparam logic [CODE_W-1:0] KEY_ONE       = 8'h02;
    localparam logic [CODE_W-1:0] KEY_ZERO      = 8'h0B;
    localparam logic [CODE_W-1:0] KEY_NINE      = 8'h0A;
    localparam logic [CODE_W-1:0] KEY_FIVE      = 8'h06;
    localparam logic [CODE_W-1:0] KEY_THREE     = 8'h04;
    localparam logic [CODE_W-1:0] KEY_SEVEN     = 8'h08;
    localparam logic [CODE_W-1:0] KEY_TWO       = 8'h03;

    // set-1 key map: {code, unshifted char, shifted char}
    localparam int KEY_COUNT = 47;
    localparam logic [CODE_W+2*CHAR_W-1:0] KEY_MAP [0:KEY_COUNT-1] = '{
        {8'h1E, 7'h61, 7'h41}, {8'h30, 7'h62, 7'h42}, {8'h2E, 7'h63, 7'h43},
        {8'h20, 7'h64, 7'h44}, {8'h12, 7'h65, 7'h45}, {8'h21, 7'h66, 7'h46},
        {8'h22, 7'h67, 7'h47}, {8'h23, 7'h68, 7'h48}, {8'h17, 7'h69, 7'h49},
        {8'h24, 7'h6A, 7'h4A}, {8'h25, 7'h6B, 7'h4B}, {8'h26, 7'h6C, 7'h4C},
        {8'h32, 7'h6D, 7'h4D}, {8'h31, 7'h6E, 7'h4E}, {8'h18, 7'h6F, 7'h4F},
        {8'h19, 7'h70, 7'h50}, {8'h10, 7'h71, 7'h51}, {8'h13, 7'h72, 7'h52},
        {8'h1F, 7'h73, 7'h53}, {8'h14, 7'h74, 7'h54}, {8'h16, 7'h75, 7'h55},
        {8'h2F, 7'h76, 7'h56}, {8'h11, 7'h77, 7'h57}, {8'h2D, 7'h78, 7'h58},
        {8'h15, 7'h79, 7'h59}, {8'h2C, 7'h7A, 7'h5A},
        // digit row
        {8'h02, 7'h31, 7'h21}, {8'h03, 7'h32, 7'h22}, {8'h04, 7'h33, 7'h40},
        {8'h05, 7'h34, 7'h24}, {8'h06, 7'h35, 7'h25}, {8'h07, 7'h36, 7'h26},
        {8'h08, 7'h37, 7'h2F}, {8'h09, 7'h38, 7'h28}, {8'h0A, 7'h39, 7'h29},
        {8'h0B, 7'h30, 7'h3D},
        // enter, escape, backspace, tab, space
        {8'h1C, 7'h0A, 7'h0A}, {8'h01, 7'h18, 7'h18}, {8'h0E, 7'h08, 7'h08},
        {8'h0F, 7'h09, 7'h09}, {8'h39, 7'h20, 7'h20},
        // punctuation
        {8'h2B, 7'h5C, 7'h7C}, {8'h28, 7'h27, 7'h3F}, {8'h4E, 7'h2B, 7'h2A},
        {8'h33, 7'h2C, 7'h3B}, {8'h34, 7'h2E, 7'h3A}, {8'h0C, 7'h2D, 7'h5F}
    };

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               char_valid;
        logic [MOD_W-1:0]   modifiers;
        logic               entry_done;
        logic [VALUE_W-1:0] entry_value;
    } t_key_result;

    typedef enum logic {ROW_KEY, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CODE_W-1:0] code;
        bit                pinned;
        t_key_result       typed;
        t_cfg_idx          idx;
        logic [CFG_DATA_W-1:0] data;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scne_in_if  in_if ();
    scne_out_if out_if ();

    scan_code_to_char_number_entry_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // keyboard model state and its configuration copy
    logic [MOD_W-1:0] mod_flags      = '0;
    logic [ACC_W-1:0] acc_value      = '0;
    logic             acc_negative   = 1'b0;
    logic             entry_at_start = 1'b1;
    logic             cfg_signed     = 1'b0;
    logic [ACC_W-1:0] cfg_start      = '0;

    t_key_result pending_results [$];
    t_row        directed_rows [$];
    int          error_count = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_req    = 0;
    int          hold_ack    = 0;
    int          hold_left   = 0;
    bit          cur_pinned  = 1'b0;
    t_key_result cur_typed   = '0;

    // translate one scan code and advance the number entry
    function automatic t_key_result translate_key(input logic [CODE_W-1:0] code);
        t_key_result r;
        logic [CHAR_W-1:0] ch;
        bit hit;
        bit is_digit;
        bit consumed;
        r = '0;
        ch = '0;
        hit = 1'b0;
        consumed = 1'b0;
        if (code == CODE_SHIFT) mod_flags[MOD_SHIFT] = 1'b1;
        if (code == (CODE_SHIFT | CODE_RELEASE)) mod_flags[MOD_SHIFT] = 1'b0;
        if (code == CODE_CTRL) mod_flags[MOD_CTRL] = 1'b1;
        if (code == (CODE_CTRL | CODE_RELEASE)) mod_flags[MOD_CTRL] = 1'b0;
        if (code == CODE_ALT) mod_flags[MOD_ALT] = 1'b1;
        if (code == (CODE_ALT | CODE_RELEASE)) mod_flags[MOD_ALT] = 1'b0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (!hit && KEY_MAP[i][CODE_W+2*CHAR_W-1:2*CHAR_W] == code) begin
                hit = 1'b1;
                ch = mod_flags[MOD_SHIFT] ? KEY_MAP[i][CHAR_W-1:0]
                                          : KEY_MAP[i][2*CHAR_W-1:CHAR_W];
            end
        end
        if (hit) begin
            is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            // first character of an entry: signed mode eats it as sign or seed
            if (entry_at_start) begin
                entry_at_start = 1'b0;
                acc_negative = 1'b0;
                if (cfg_signed) begin
                    acc_value = is_digit ? ACC_W'(ch - CH_ZERO) : '0;
                    acc_negative = (ch == CH_MINUS);
                    consumed = 1'b1;
                end else begin
                    acc_value = cfg_start;
                end
            end
            if (!consumed) begin
                if (ch == CH_BACKSPACE) begin
                    acc_value = acc_value / 10;
                end else if (ch == CH_NEWLINE) begin
                    r.entry_value = acc_negative ? VALUE_W'(-acc_value) : VALUE_W'(acc_value);
                    r.entry_done = 1'b1;
                    acc_value = '0;
                    acc_negative = 1'b0;
                    entry_at_start = 1'b1;
                end else if (is_digit) begin
                    acc_value = acc_value * ACC_W'(10) + ACC_W'(ch - CH_ZERO);
                end
            end
        end
        r.char_out = ch;
        r.char_valid = hit;
        r.modifiers = mod_flags;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
            error_count++;
        end
    endfunction

    function automatic t_row key_row(input logic [CODE_W-1:0] code);
        t_row r;
        r = '{ROW_KEY, code, 1'b0, '0, CFG_SIGNED_MODE, '0};
        return r;
    endfunction

    function automatic t_row pinned_row(input logic [CODE_W-1:0] code,
                                        input logic [CHAR_W-1:0] ch, input logic valid,
                                        input logic [MOD_W-1:0] mods, input logic done,
                                        input logic [VALUE_W-1:0] value);
        t_row r;
        r = '{ROW_KEY, code, 1'b1, '{ch, valid, mods, done, value}, CFG_SIGNED_MODE, '0};
        return r;
    endfunction

    function automatic t_row cfg_row(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '{ROW_CFG, '0, 1'b0, '0, idx, data};
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // monitor: register writes, result checks, expectations per scan code transfer
    always @(posedge i_clk) begin
        t_key_result expected;
        t_key_result predicted;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SIGNED_MODE: cfg_signed = i_cfg_data[0];
                    CFG_START_VALUE: cfg_start = i_cfg_data;
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %0h/%0b/%0h/%0b/%0h",
                             $time, out_if.char_out, out_if.char_valid, out_if.modifiers,
                             out_if.entry_done, out_if.entry_value);
                    error_count++;
                end else begin
                    expected = pending_results.pop_front();
                    check_field("char_out", expected.char_out, out_if.char_out);
                    check_field("char_valid", expected.char_valid, out_if.char_valid);
                    check_field("modifiers", expected.modifiers, out_if.modifiers);
                    check_field("entry_done", expected.entry_done, out_if.entry_done);
                    check_field("entry_value", expected.entry_value, out_if.entry_value);
                end
            end
            if (in_if.valid && in_if.ready) begin
                predicted = translate_key(in_if.scan_code);
                pending_results.push_back(cur_pinned ? cur_typed : predicted);
            end
        end
    end

    // offer one scan code, called and returning at a falling edge
    task automatic send_code(input logic [CODE_W-1:0] code, input bit pinned = 1'b0,
                             input t_key_result typed = '0);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.scan_code <= code;
        cur_pinned      <= pinned;
        cur_typed       <= typed;
        @(posedge i_clk);
        while (!(in_if.valid && in_if.ready)) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and let every expected result come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one number entry with random content, sometimes with modifiers or a sign
    task automatic send_number_entry();
        logic [CODE_W-1:0] mod_code;
        int n;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0: mod_code = CODE_SHIFT;
                1: mod_code = CODE_CTRL;
                default: mod_code = CODE_ALT;
            endcase
            send_code(mod_code | ($urandom_range(0, 1) ? CODE_RELEASE : 8'h00));
        end
        if ($urandom_range(0, 3) != 0) send_code(CODE_SHIFT | CODE_RELEASE);
        if ($urandom_range(0, 2) == 0) send_code(KEY_MINUS);
        n = $urandom_range(0, 12);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: send_code(KEY_BACKSPACE);
                1: send_code(KEY_MAP[$urandom_range(0, KEY_COUNT-1)][CODE_W+2*CHAR_W-1:2*CHAR_W]);
                default: send_code(CODE_W'($urandom_range(KEY_ONE, KEY_ZERO)));
            endcase
        end
        send_code(KEY_ENTER);
    endtask

    // stimulus
    initial begin
        logic [1:0] signed_plan [SEGMENTS];
        logic [CFG_DATA_W-1:0] start_plan [SEGMENTS];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.scan_code = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: extremes, modifiers, entry start cases in both modes
        directed_rows.push_back(cfg_row(CFG_SIGNED_MODE, 32'd0));
        directed_rows.push_back(cfg_row(CFG_START_VALUE, 32'd0));
        directed_rows.push_back(pinned_row(8'h00, 7'h00, 1'b0, 3'd0, 1'b0, 32'd0));
        directed_rows.push_back(pinned_row(8'hFF, 7'h00, 1'b0, 3'd0, 1'b0, 32'd0));
        directed_rows.push_back(pinned_row(KEY_ENTER, CH_NEWLINE, 1'b1, 3'd0, 1'b1, 32'd0));
        directed_rows.push_back(key_row(KEY_ONE));
        directed_rows.push_back(key_row(KEY_TWO));
        directed_rows.push_back(key_row(KEY_BACKSPACE));
        directed_rows.push_back(pinned_row(CODE_SHIFT, 7'h00, 1'b0, 3'd1, 1'b0, 32'd0));
        directed_rows.push_back(key_row(KEY_ZERO));
        directed_rows.push_back(pinned_row(CODE_SHIFT | CODE_RELEASE, 7'h00, 1'b0, 3'd0,
                                           1'b0, 32'd0));
        directed_rows.push_back(pinned_row(CODE_CTRL, 7'h00, 1'b0, 3'd2, 1'b0, 32'd0));
        directed_rows.push_back(pinned_row(CODE_ALT, 7'h00, 1'b0, 3'd6, 1'b0, 32'd0));
        directed_rows.push_back(pinned_row(CODE_CTRL | CODE_RELEASE, 7'h00, 1'b0, 3'd4,
                                           1'b0, 32'd0));
        directed_rows.push_back(pinned_row(CODE_ALT | CODE_RELEASE, 7'h00, 1'b0, 3'd0,
                                           1'b0, 32'd0));
        directed_rows.push_back(key_row(KEY_ENTER));
        directed_rows.push_back(cfg_row(CFG_START_VALUE, 32'hFFFF_FFFF));
        directed_rows.push_back(pinned_row(KEY_ENTER, CH_NEWLINE, 1'b1, 3'd0, 1'b1,
                                           32'hFFFF_FFFF));
        directed_rows.push_back(key_row(KEY_NINE));
        directed_rows.push_back(key_row(KEY_ENTER));
        directed_rows.push_back(cfg_row(CFG_SIGNED_MODE, 32'd1));
        // newline as first signed character is swallowed
        directed_rows.push_back(pinned_row(KEY_ENTER, CH_NEWLINE, 1'b1, 3'd0, 1'b0, 32'd0));
        directed_rows.push_back(key_row(KEY_ENTER));
        directed_rows.push_back(pinned_row(KEY_MINUS, CH_MINUS, 1'b1, 3'd0, 1'b0, 32'd0));
        directed_rows.push_back(key_row(KEY_FIVE));
        directed_rows.push_back(key_row(KEY_THREE));
        directed_rows.push_back(key_row(KEY_ENTER));
        directed_rows.push_back(key_row(KEY_SEVEN));
        directed_rows.push_back(key_row(KEY_ENTER));

        tx_idle_pct = 32;
        rx_idle_pct = 86;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_register(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_code(directed_rows[i].code, directed_rows[i].pinned,
                          directed_rows[i].typed);
            end
        end

        // random part: segments with their own settings and idling profile
        signed_plan = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0};
        start_plan  = '{$urandom(), 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(), 32'd0};
        for (int s = 0; s < SEGMENTS; s++) begin
            write_register(CFG_SIGNED_MODE, CFG_DATA_W'(signed_plan[s]));
            write_register(CFG_START_VALUE, start_plan[s]);
            case (s / 2)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 86;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // long receiver hold-off while codes keep coming
            if (s == 4) hold_req++;
            while (items_sent < directed_rows.size() + SEG_ITEMS * (s + 1)) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_code(CODE_W'($urandom_range(0, 255)));
                end else begin
                    send_number_entry();
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/scne_pkg.sv
src/scne_in_if.sv
src/scne_out_if.sv
src/scan_code_to_char_number_entry_unit.sv
bench/tb_top.sv
